[sv/rxd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxd_pkg
// Shared constants, codes and types of the run-length / xor-delta pixel
// decoder.
// ----------------------------------------------------------------------------
package rxd_pkg;

   parameter int FRAME_PIXELS = 131072;
   // frame store address width and pixel position width (position saturates
   // at FRAME_PIXELS, so it needs one more code than the store)
   parameter int PIX_AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
   parameter int POS_W  = $clog2(FRAME_PIXELS + 1);

   parameter int BYTE_W   = 8;
   parameter int TRIPLE_W = 3 * BYTE_W;
   parameter int INDEX_W  = 17;
   parameter int STATUS_W = 2;

   parameter int QUEUE_DEPTH = 4;
   parameter int QPTR_W      = $clog2(QUEUE_DEPTH);
   parameter int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // repeat count at which the next data byte is a run length
   parameter logic [1:0] MATCH_FOR_COUNT = 2'd2;
   // bytes held before the third byte of a triple arrives
   parameter logic [1:0] PARTIAL_BYTES = 2'd2;

   typedef enum logic [0:0] {
      REQ_BYTE = 1'b0,
      REQ_PULL = 1'b1
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_WRITTEN  = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_BEYOND   = 2'd2
   } status_type;

   // one unit of work handed from the front part to the back part
   typedef struct packed {
      logic                reject;
      logic                beyond;
      logic [TRIPLE_W-1:0] triple;
      logic [POS_W-1:0]    pos;
      logic                run_end;
      logic                frame_end;
   } op_type;

endpackage

[sv/rxd_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxd_req_if
// Request channel: stream bytes and run pulls, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rxd_req_if;

   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic [rxd_pkg::BYTE_W-1:0] data_byte;
   logic                       frame_last;

   modport source (
      output valid,
      output req_type,
      output data_byte,
      output frame_last,
      input  ready
   );

   modport sink (
      input  valid,
      input  req_type,
      input  data_byte,
      input  frame_last,
      output ready
   );

endinterface

[sv/rxd_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxd_rsp_if
// Response channel: decoded pixels and reject notices, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rxd_rsp_if;

   logic                         valid;
   logic                         ready;
   logic [rxd_pkg::STATUS_W-1:0] status;
   logic [rxd_pkg::INDEX_W-1:0]  pixel_index;
   logic [rxd_pkg::BYTE_W-1:0]   first_byte;
   logic [rxd_pkg::BYTE_W-1:0]   second_byte;
   logic [rxd_pkg::BYTE_W-1:0]   third_byte;
   logic                         run_end;
   logic                         frame_end;

   modport source (
      output valid,
      output status,
      output pixel_index,
      output first_byte,
      output second_byte,
      output third_byte,
      output run_end,
      output frame_end,
      input  ready
   );

   modport sink (
      input  valid,
      input  status,
      input  pixel_index,
      input  first_byte,
      input  second_byte,
      input  third_byte,
      input  run_end,
      input  frame_end,
      output ready
   );

endinterface

[sv/rxd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxd_front
// Stream parser: assembles triples, tracks repeats and run counts, and
// issues pixel and reject operations into the op queue.
// ----------------------------------------------------------------------------
module rxd_front (
   input  logic                clock,
   input  logic                reset,
   rxd_req_if.sink             req_ch,
   input  logic                q_full,
   output logic                push,
   output rxd_pkg::op_type     push_op
);

   localparam logic [rxd_pkg::POS_W-1:0] POS_LIMIT =
      rxd_pkg::POS_W'(rxd_pkg::FRAME_PIXELS);

   logic [rxd_pkg::TRIPLE_W-1:0]   held_ff, held_in;
   logic [1:0]                     match_ff, match_in;
   logic                           fresh_ff, fresh_in;
   logic [1:0]                     phase_ff, phase_in;
   logic [2*rxd_pkg::BYTE_W-1:0]   partial_ff, partial_in;
   logic                           expect_ff, expect_in;
   logic [rxd_pkg::BYTE_W-1:0]     run_left_ff, run_left_in;
   logic [rxd_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic                           end_after_ff, end_after_in;

   logic                           accept;
   logic                           clear;
   logic                           ends;
   logic [rxd_pkg::TRIPLE_W-1:0]   triple;
   logic [rxd_pkg::POS_W-1:0]      next_pos;
   logic                           beyond;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign triple       = {partial_ff, req_ch.data_byte};
   assign beyond       = (pos_ff >= POS_LIMIT);
   // position saturates once past the store
   assign next_pos     = beyond ? pos_ff : pos_ff + rxd_pkg::POS_W'(1);
   assign ends         = (run_left_ff == rxd_pkg::BYTE_W'(1));

   always_comb begin
      held_in      = held_ff;
      match_in     = match_ff;
      fresh_in     = fresh_ff;
      phase_in     = phase_ff;
      partial_in   = partial_ff;
      expect_in    = expect_ff;
      run_left_in  = run_left_ff;
      pos_in       = pos_ff;
      end_after_in = end_after_ff;
      clear        = 1'b0;
      push         = 1'b0;
      push_op      = '0;

      if (accept) begin
         if (req_ch.req_type == rxd_pkg::REQ_PULL) begin
            if (run_left_ff != '0) begin
               run_left_in       = run_left_ff - rxd_pkg::BYTE_W'(1);
               push              = 1'b1;
               push_op.beyond    = beyond;
               push_op.triple    = held_ff;
               push_op.pos       = pos_ff;
               push_op.run_end   = ends;
               push_op.frame_end = ends && end_after_ff;
               pos_in            = next_pos;
               clear             = ends && end_after_ff;
            end
         end else if (run_left_ff != '0) begin
            push           = 1'b1;
            push_op.reject = 1'b1;
         end else if (expect_ff) begin
            expect_in   = 1'b0;
            run_left_in = req_ch.data_byte;
            fresh_in    = 1'b1;
            match_in    = '0;
            if (req_ch.frame_last) begin
               if (req_ch.data_byte != '0) begin
                  end_after_in = 1'b1;
               end else begin
                  clear = 1'b1;
               end
            end
         end else if (phase_ff < rxd_pkg::PARTIAL_BYTES) begin
            partial_in = {partial_ff[rxd_pkg::BYTE_W-1:0], req_ch.data_byte};
            phase_in   = phase_ff + 2'd1;
            clear      = req_ch.frame_last;
         end else begin
            phase_in   = '0;
            partial_in = '0;
            if (fresh_ff || (triple == held_ff)) begin
               match_in = match_ff + 2'd1;
            end else begin
               match_in = '0;
            end
            held_in           = triple;
            fresh_in          = 1'b0;
            push              = 1'b1;
            push_op.beyond    = beyond;
            push_op.triple    = triple;
            push_op.pos       = pos_ff;
            push_op.frame_end = req_ch.frame_last;
            pos_in            = next_pos;
            if (req_ch.frame_last) begin
               clear = 1'b1;
            end else if (match_in == rxd_pkg::MATCH_FOR_COUNT) begin
               expect_in = 1'b1;
            end
         end
      end

      // frame end: per-frame state returns to its start values
      if (clear) begin
         held_in      = '0;
         match_in     = '0;
         fresh_in     = 1'b1;
         phase_in     = '0;
         partial_in   = '0;
         expect_in    = 1'b0;
         run_left_in  = '0;
         pos_in       = '0;
         end_after_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         match_ff     <= '0;
         fresh_ff     <= 1'b1;
         phase_ff     <= '0;
         partial_ff   <= '0;
         expect_ff    <= 1'b0;
         run_left_ff  <= '0;
         pos_ff       <= '0;
         end_after_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         match_ff     <= match_in;
         fresh_ff     <= fresh_in;
         phase_ff     <= phase_in;
         partial_ff   <= partial_in;
         expect_ff    <= expect_in;
         run_left_ff  <= run_left_in;
         pos_ff       <= pos_in;
         end_after_ff <= end_after_in;
      end
   end

endmodule

[sv/rxd_op_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxd_op_queue
// Small FIFO of operations between the parser and the frame store stage.
// ----------------------------------------------------------------------------
module rxd_op_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rxd_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output logic            empty,
   output rxd_pkg::op_type head_op
);

   rxd_pkg::op_type                 entry_ff [rxd_pkg::QUEUE_DEPTH];
   logic [rxd_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [rxd_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [rxd_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full    = (count_ff == rxd_pkg::QCNT_W'(rxd_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head_op = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + rxd_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + rxd_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + rxd_pkg::QCNT_W'(push) - rxd_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

[sv/rxd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxd_back
// Frame store stage: reads the previous frame's pixel, xors, writes back
// (in-range pixels only), and holds the result in the output register.
// ----------------------------------------------------------------------------
module rxd_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  rxd_pkg::op_type head_op,
   output logic            pop,
   rxd_rsp_if.source       rsp_ch
);

   logic [rxd_pkg::TRIPLE_W-1:0] store_mem [rxd_pkg::FRAME_PIXELS];

   // stage 1: op waiting on its store read
   logic                         s1_valid_ff, s1_valid_in;
   rxd_pkg::op_type              s1_op_ff;
   logic [rxd_pkg::TRIPLE_W-1:0] rd_data_ff;
   logic                         rd_blank_ff;

   // positions at and above fill_ff were never written and read as zero
   logic [rxd_pkg::POS_W-1:0]    fill_ff, fill_in;
   logic                         last_wr_valid_ff;
   logic [rxd_pkg::PIX_AW-1:0]   last_wr_addr_ff;
   logic [rxd_pkg::TRIPLE_W-1:0] last_wr_data_ff;

   // output register
   logic                         out_valid_ff, out_valid_in;
   rxd_pkg::status_type          out_status_ff;
   logic [rxd_pkg::INDEX_W-1:0]  out_index_ff;
   logic [rxd_pkg::TRIPLE_W-1:0] out_pixel_ff;
   logic                         out_run_end_ff;
   logic                         out_frame_end_ff;

   logic                         advance;
   logic                         retire;
   logic                         do_write;
   logic [rxd_pkg::PIX_AW-1:0]   head_addr;
   logic [rxd_pkg::PIX_AW-1:0]   s1_addr;
   logic [rxd_pkg::TRIPLE_W-1:0] prev_pixel;
   logic [rxd_pkg::TRIPLE_W-1:0] new_pixel;

   assign advance   = !out_valid_ff || rsp_ch.ready;
   assign pop       = !q_empty && (!s1_valid_ff || advance);
   assign retire    = s1_valid_ff && advance;
   assign head_addr = head_op.pos[rxd_pkg::PIX_AW-1:0];
   assign s1_addr   = s1_op_ff.pos[rxd_pkg::PIX_AW-1:0];
   assign do_write  = retire && !s1_op_ff.reject && !s1_op_ff.beyond;

   always_comb begin
      // the last write may have landed after this op's read was issued
      if (last_wr_valid_ff && (last_wr_addr_ff == s1_addr)) begin
         prev_pixel = last_wr_data_ff;
      end else if (rd_blank_ff) begin
         prev_pixel = '0;
      end else begin
         prev_pixel = rd_data_ff;
      end
      new_pixel = s1_op_ff.beyond ? s1_op_ff.triple : (s1_op_ff.triple ^ prev_pixel);

      s1_valid_in  = pop ? 1'b1 : (retire ? 1'b0 : s1_valid_ff);
      out_valid_in = retire ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
      fill_in      = fill_ff;
      if (do_write && (s1_op_ff.pos >= fill_ff)) begin
         fill_in = s1_op_ff.pos + rxd_pkg::POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         fill_ff          <= '0;
         last_wr_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         fill_ff      <= fill_in;
         if (do_write) begin
            last_wr_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_op_ff    <= head_op;
         rd_data_ff  <= store_mem[head_addr];
         rd_blank_ff <= (head_op.pos >= fill_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         store_mem[s1_addr] <= new_pixel;
         last_wr_addr_ff    <= s1_addr;
         last_wr_data_ff    <= new_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (retire) begin
         if (s1_op_ff.reject) begin
            out_status_ff    <= rxd_pkg::STATUS_REJECTED;
            out_index_ff     <= '0;
            out_pixel_ff     <= '0;
            out_run_end_ff   <= 1'b0;
            out_frame_end_ff <= 1'b0;
         end else begin
            out_status_ff    <= s1_op_ff.beyond ? rxd_pkg::STATUS_BEYOND
                                                : rxd_pkg::STATUS_WRITTEN;
            out_index_ff     <= s1_op_ff.pos[rxd_pkg::INDEX_W-1:0];
            out_pixel_ff     <= new_pixel;
            out_run_end_ff   <= s1_op_ff.run_end;
            out_frame_end_ff <= s1_op_ff.frame_end;
         end
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.status      = out_status_ff;
   assign rsp_ch.pixel_index = out_index_ff;
   assign rsp_ch.first_byte  = out_pixel_ff[3*rxd_pkg::BYTE_W-1:2*rxd_pkg::BYTE_W];
   assign rsp_ch.second_byte = out_pixel_ff[2*rxd_pkg::BYTE_W-1:rxd_pkg::BYTE_W];
   assign rsp_ch.third_byte  = out_pixel_ff[rxd_pkg::BYTE_W-1:0];
   assign rsp_ch.run_end     = out_run_end_ff;
   assign rsp_ch.frame_end   = out_frame_end_ff;

endmodule

[sv/rle_xor_delta_pixel_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_xor_delta_pixel_decoder
// Run-length decoder of three-byte pixels with xor delta against the
// previous frame, held in an on-chip frame store.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake     | transaction
//  ---------+-----------+---------------+------------------------------------
//  req_ch   | in        | valid / ready | stream byte or run pull
//  rsp_ch   | out       | valid / ready | decoded pixel or reject notice
//
//  one transaction per cycle in while the op queue has room, one per cycle
//  out while rsp_ch is ready; pixels pass queue, store read, output register.
//  synchronous reset; the frame store reads as zero until written, tracked by
//  a fill count, so the block takes transactions from the first cycle.
//  req_ch.ready drops only when the 4-entry op queue is full; rsp_ch stalls
//  back up through the store stage into that queue.
// ----------------------------------------------------------------------------
module rle_xor_delta_pixel_decoder (
   input  logic      clock,
   input  logic      reset,
   rxd_req_if.sink   req_ch,
   rxd_rsp_if.source rsp_ch
);

   logic            q_full;
   logic            q_empty;
   logic            push;
   logic            pop;
   rxd_pkg::op_type push_op;
   rxd_pkg::op_type head_op;

   rxd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_full  (q_full),
      .push    (push),
      .push_op (push_op)
   );

   rxd_op_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (q_full),
      .pop     (pop),
      .empty   (q_empty),
      .head_op (head_op)
   );

   rxd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .head_op (head_op),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

[tb/tb_rle_xor_delta_pixel_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rle_xor_delta_pixel_decoder
// Self-checking bench for the run-length / xor-delta pixel decoder. A queue of
// stream bytes and run pulls feeds a clocked driver. Each accepted transaction
// goes through a local decoder model with its own frame store, and the model
// queues the expected pixels. A clocked monitor checks every result field by
// field. Sender and receiver idle in three mixes. The receiver holds off for a
// long stretch so that the block fills up.
// ----------------------------------------------------------------------------
module tb_rle_xor_delta_pixel_decoder;

   localparam int HOLD_CYCLES = 64;
   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 20;
   localparam int PHASE_ITEMS = 150;

   typedef struct packed {
      rxd_pkg::req_kind_type      kind;
      logic [rxd_pkg::BYTE_W-1:0] data;
      logic                       last;
      logic                       drain;
   } stream_item_type;

   typedef struct packed {
      rxd_pkg::status_type         status;
      logic [rxd_pkg::INDEX_W-1:0] index;
      logic [rxd_pkg::BYTE_W-1:0]  b0;
      logic [rxd_pkg::BYTE_W-1:0]  b1;
      logic [rxd_pkg::BYTE_W-1:0]  b2;
      logic                        run_end;
      logic                        frame_end;
   } pixel_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rxd_req_if req_ch ();
   rxd_rsp_if rsp_ch ();

   rle_xor_delta_pixel_decoder i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   stream_item_type stream_q[$];
   pixel_rsp_type   pixel_expect_q[$];
   stream_item_type cur_item;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_done    = 0;
   int unsigned hold_left     = 0;
   int unsigned error_count   = 0;
   int unsigned stall_cycles  = 0;
   int unsigned items_queued  = 0;
   bit          drain_next    = 1'b0;

   // decoder state as the block should hold it
   bit   [rxd_pkg::TRIPLE_W-1:0] frame_mem [rxd_pkg::FRAME_PIXELS];
   logic [rxd_pkg::TRIPLE_W-1:0] held_px;
   logic [1:0]                   match_cnt;
   bit                           fresh_grp;
   logic [1:0]                   phase_cnt;
   logic [2*rxd_pkg::BYTE_W-1:0] part_bytes;
   bit                           want_count;
   logic [rxd_pkg::BYTE_W-1:0]   run_cnt;
   int unsigned                  pix_pos;
   bit                           end_after_run;

   function void clear_frame_state();
      held_px       = '0;
      match_cnt     = '0;
      fresh_grp     = 1'b1;
      phase_cnt     = '0;
      part_bytes    = '0;
      want_count    = 1'b0;
      run_cnt       = '0;
      pix_pos       = 0;
      end_after_run = 1'b0;
   endfunction

   function void emit_pixel(logic [rxd_pkg::TRIPLE_W-1:0] triple, bit run_end,
                            bit frame_end);
      pixel_rsp_type                px;
      logic [rxd_pkg::TRIPLE_W-1:0] val;
      val       = triple;
      px.status = rxd_pkg::STATUS_BEYOND;
      if (pix_pos < rxd_pkg::FRAME_PIXELS) begin
         val                = val ^ frame_mem[pix_pos];
         frame_mem[pix_pos] = val;
         px.status          = rxd_pkg::STATUS_WRITTEN;
      end
      px.index     = rxd_pkg::INDEX_W'(pix_pos);
      px.b0        = val[23:16];
      px.b1        = val[15:8];
      px.b2        = val[7:0];
      px.run_end   = run_end;
      px.frame_end = frame_end;
      pixel_expect_q.push_back(px);
      if (pix_pos < rxd_pkg::FRAME_PIXELS) pix_pos++;
   endfunction

   function void decode_item(stream_item_type it);
      logic [rxd_pkg::TRIPLE_W-1:0] triple;
      bit                           ends;
      pixel_rsp_type                rej;
      if (it.kind == rxd_pkg::REQ_PULL) begin
         if (run_cnt != 0) begin
            run_cnt--;
            ends = (run_cnt == 0);
            emit_pixel(held_px, ends, ends && end_after_run);
            if (ends && end_after_run) clear_frame_state();
         end
      end else if (run_cnt != 0) begin
         rej        = '0;
         rej.status = rxd_pkg::STATUS_REJECTED;
         pixel_expect_q.push_back(rej);
      end else if (want_count) begin
         want_count = 1'b0;
         run_cnt    = it.data;
         fresh_grp  = 1'b1;
         match_cnt  = '0;
         if (it.last) begin
            if (run_cnt != 0) end_after_run = 1'b1;
            else clear_frame_state();
         end
      end else if (phase_cnt < rxd_pkg::PARTIAL_BYTES) begin
         part_bytes = {part_bytes[rxd_pkg::BYTE_W-1:0], it.data};
         phase_cnt++;
         if (it.last) clear_frame_state();
      end else begin
         triple     = {part_bytes, it.data};
         phase_cnt  = '0;
         part_bytes = '0;
         if (fresh_grp || triple == held_px) match_cnt = match_cnt + 2'd1;
         else match_cnt = '0;
         held_px   = triple;
         fresh_grp = 1'b0;
         emit_pixel(triple, 1'b0, it.last);
         if (it.last) clear_frame_state();
         else if (match_cnt == rxd_pkg::MATCH_FOR_COUNT) want_count = 1'b1;
      end
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   function void check_pixel();
      pixel_rsp_type want;
      if (pixel_expect_q.size() == 0) begin
         error_count++;
         $display("%0t: unexpected result, expected none, actual status %0h index %0h",
                  $time, rsp_ch.status, rsp_ch.pixel_index);
      end else begin
         want = pixel_expect_q.pop_front();
         compare_field("status", want.status, rsp_ch.status);
         compare_field("pixel_index", want.index, rsp_ch.pixel_index);
         compare_field("first_byte", want.b0, rsp_ch.first_byte);
         compare_field("second_byte", want.b1, rsp_ch.second_byte);
         compare_field("third_byte", want.b2, rsp_ch.third_byte);
         compare_field("run_end", want.run_end, rsp_ch.run_end);
         compare_field("frame_end", want.frame_end, rsp_ch.frame_end);
      end
   endfunction

   // ---- stimulus building ----

   function void queue_item(rxd_pkg::req_kind_type kind,
                            logic [rxd_pkg::BYTE_W-1:0] data, bit last);
      stream_item_type it;
      it.kind    = kind;
      it.data    = data;
      it.last    = last;
      it.drain   = drain_next;
      drain_next = 1'b0;
      stream_q.push_back(it);
      items_queued++;
   endfunction

   function void queue_triple(logic [rxd_pkg::TRIPLE_W-1:0] t, bit last);
      queue_item(rxd_pkg::REQ_BYTE, t[23:16], 1'b0);
      queue_item(rxd_pkg::REQ_BYTE, t[15:8], 1'b0);
      queue_item(rxd_pkg::REQ_BYTE, t[7:0], last);
   endfunction

   // copies of the triple, the count byte, then one pull per repeat with an
   // occasional stray byte that must be rejected
   function void queue_run(logic [rxd_pkg::TRIPLE_W-1:0] t, int unsigned copies,
                           logic [rxd_pkg::BYTE_W-1:0] count, bit last);
      repeat (copies) queue_triple(t, 1'b0);
      queue_item(rxd_pkg::REQ_BYTE, count, last);
      repeat (count) begin
         if ($urandom_range(99) < 5)
            queue_item(rxd_pkg::REQ_BYTE, rxd_pkg::BYTE_W'($urandom),
                       1'($urandom_range(1)));
         queue_item(rxd_pkg::REQ_PULL, rxd_pkg::BYTE_W'($urandom),
                    1'($urandom_range(1)));
      end
   endfunction

   function logic [rxd_pkg::BYTE_W-1:0] pick_count();
      if ($urandom_range(99) < 4) return rxd_pkg::BYTE_W'($urandom_range(255));
      return rxd_pkg::BYTE_W'($urandom_range(6));
   endfunction

   function void queue_random_frame();
      int unsigned                  pick;
      bit                           fresh;
      logic [rxd_pkg::TRIPLE_W-1:0] t;
      fresh = 1'b1;
      if ($urandom_range(99) < 15) drain_next = 1'b1;
      repeat ($urandom_range(6)) begin
         pick = $urandom_range(99);
         t    = rxd_pkg::TRIPLE_W'($urandom);
         if (pick < 45) begin
            queue_triple(t, 1'b0);
            fresh = 1'b0;
         end else if (pick < 93) begin
            queue_run(t, fresh ? 2 : 3, pick_count(), 1'b0);
            fresh = 1'b1;
         end else begin
            queue_item(rxd_pkg::req_kind_type'($urandom_range(1)),
                       rxd_pkg::BYTE_W'($urandom), 1'($urandom_range(1)));
         end
      end
      t = rxd_pkg::TRIPLE_W'($urandom);
      case ($urandom_range(5))
         0, 1: queue_triple(t, 1'b1);
         2: queue_run(t, fresh ? 2 : 3, rxd_pkg::BYTE_W'($urandom_range(1, 6)), 1'b1);
         3: queue_run(t, fresh ? 2 : 3, '0, 1'b1);
         4: begin
            // partial triple cut off by the end of the frame
            if ($urandom_range(1))
               queue_item(rxd_pkg::REQ_BYTE, rxd_pkg::BYTE_W'($urandom), 1'b0);
            queue_item(rxd_pkg::REQ_BYTE, rxd_pkg::BYTE_W'($urandom), 1'b1);
         end
         default: begin
            // second repeat lands on the final byte
            if (!fresh) queue_triple(t, 1'b0);
            queue_triple(t, 1'b0);
            queue_triple(t, 1'b1);
         end
      endcase
   endfunction

   function void queue_directed();
      queue_item(rxd_pkg::REQ_PULL, 8'hff, 1'b1);
      queue_triple(24'h000000, 1'b0);
      queue_triple(24'h000000, 1'b0);
      queue_item(rxd_pkg::REQ_BYTE, 8'd2, 1'b1);
      queue_item(rxd_pkg::REQ_BYTE, 8'hff, 1'b1);
      queue_item(rxd_pkg::REQ_PULL, 8'h00, 1'b0);
      queue_item(rxd_pkg::REQ_PULL, 8'h00, 1'b0);
      queue_item(rxd_pkg::REQ_PULL, 8'h00, 1'b0);
      queue_triple(24'hffffff, 1'b0);
      queue_triple(24'hffffff, 1'b1);
      queue_item(rxd_pkg::REQ_BYTE, 8'haa, 1'b0);
      queue_item(rxd_pkg::REQ_BYTE, 8'h55, 1'b1);
      queue_triple(24'h123456, 1'b0);
      queue_triple(24'h123456, 1'b0);
      queue_item(rxd_pkg::REQ_BYTE, 8'h00, 1'b1);
   endfunction

   task wait_for_idle();
      while (stream_q.size() != 0 || req_ch.valid || pixel_expect_q.size() != 0)
         @(negedge clock);
   endtask

   // ---- driver ----

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid      <= 1'b0;
         req_ch.req_type   <= rxd_pkg::REQ_BYTE;
         req_ch.data_byte  <= '0;
         req_ch.frame_last <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) decode_item(cur_item);
         if (!req_ch.valid || req_ch.ready) begin
            if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct
                && !(stream_q[0].drain && pixel_expect_q.size() != 0)) begin
               cur_item          = stream_q.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.req_type   <= cur_item.kind;
               req_ch.data_byte  <= cur_item.data;
               req_ch.frame_last <= cur_item.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---- monitor ----

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_pixel();
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // cycles without any transaction on either channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int unsigned phase_end;
      clear_frame_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 3; p++) begin
         @(negedge clock);
         send_idle_pct = (p == 0) ? 11 : (p == 1) ? 88 : 0;
         recv_idle_pct = (p == 0) ? 88 : (p == 1) ? 11 : 0;
         if (p == 0) queue_directed();
         phase_end  = items_queued + PHASE_ITEMS;
         drain_next = 1'b1;
         while (items_queued < phase_end) queue_random_frame();
         // long receiver hold while the sender keeps offering
         if (p != 1) hold_requests++;
         wait_for_idle();
      end
      repeat (3) queue_random_frame();
      wait_for_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pixel_expect_q.size() != 0)
         $display("%0t: missing results, expected %0d more, actual none",
                  $time, pixel_expect_q.size());
      if (error_count == 0 && pixel_expect_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[rle_xor_delta_pixel_decoder.f]
sv/rxd_pkg.sv
sv/rxd_req_if.sv
sv/rxd_rsp_if.sv
sv/rxd_front.sv
sv/rxd_op_queue.sv
sv/rxd_back.sv
sv/rle_xor_delta_pixel_decoder.sv
tb/tb_rle_xor_delta_pixel_decoder.sv
